>>> hw/rtl/pidt_pkg.sv
// Shared types, constants and helpers for the priority interrupt dispatch table.
// No dependencies; used by the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package pidt_pkg;

    // Table depth, which sets the priority slots and the memory size.
    localparam int TABLE_ENTRIES = 8;
    // A dispatch emits at most this many beats.
    localparam int RESULT_LIMIT  = 8;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int HIT_W = $clog2(RESULT_LIMIT + 1);

    // Function codes of an input beat.
    localparam logic [1:0] FUNC_REGISTER = 2'd0;
    localparam logic [1:0] FUNC_ENABLE   = 2'd1;
    localparam logic [1:0] FUNC_DISABLE  = 2'd2;
    localparam logic [1:0] FUNC_DISPATCH = 2'd3;

    // Bank codes.
    localparam logic [1:0] BANK_BASIC = 2'd0;
    localparam logic [1:0] BANK_ONE   = 2'd1;
    localparam logic [1:0] BANK_TWO   = 2'd2;

    // Result kinds.
    localparam logic KIND_REG      = 1'b0;
    localparam logic KIND_DISPATCH = 1'b1;

    // One table slot as stored in memory.
    typedef struct packed {
        logic [1:0] bank;
        logic [4:0] bitpos;
        logic [7:0] handler;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Low three bits of a slot number, as reported on the result port.
    function automatic logic [2:0] slot_to_index(input logic [IDX_W-1:0] slot);
        logic [31:0] wide;
        wide = 32'(slot);
        return wide[2:0];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/priority_interrupt_dispatch_table_top.sv
// Top level of the priority interrupt dispatch table: command decode, enable
// masks and the dispatch scan. Depends on pidt_pkg and pidt_ram.
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Handshake               | Payload
// ----------+-------------------------+------------------------------------------------
// command   | i_start high, o_busy low | i_func, i_source, i_handler_id, i_raw_basic,
//           |                         | i_raw_bank_one, i_raw_bank_two
// result    | o_strobe, one cycle     | o_kind, o_accepted, o_entry_index,
//           |                         | o_handler_out, o_last
//
// Register, enable and disable commands finish in the cycle they are taken; a
// registration answer appears on the result ports in the next cycle and o_busy
// never rises for them. A dispatch reads the slot memory once per registered
// slot, one slot per cycle, and holds o_busy through the scan and flush states.
// Stopping at the eighth hit does not shorten the scan, since the eighth hit
// can only come from the last slot.
// Reset is synchronous and active low; it empties the table and clears all
// enable masks. The receiver cannot stall, so every result beat is final.

module priority_interrupt_dispatch_table_top
    import pidt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire logic [1:0]        i_func,
    input  wire logic signed [6:0] i_source,
    input  wire logic [7:0]        i_handler_id,
    input  wire logic [31:0]       i_raw_basic,
    input  wire logic [31:0]       i_raw_bank_one,
    input  wire logic [31:0]       i_raw_bank_two,
    output logic                   o_strobe,
    output logic                   o_kind,
    output logic                   o_accepted,
    output logic [2:0]             o_entry_index,
    output logic [7:0]             o_handler_out,
    output logic                   o_last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    t_state r_state;

    // Table fill level and the three enable masks.
    logic [CNT_W-1:0] r_count;
    logic [31:0]      r_en_basic;
    logic [31:0]      r_en_one;
    logic [31:0]      r_en_two;

    // Masked pending words captured when a dispatch is taken.
    logic [31:0]      r_pend_basic;
    logic [31:0]      r_pend_one;
    logic [31:0]      r_pend_two;

    // Scan pipeline: the issue index, the slot whose read data arrives now,
    // and a one-deep buffer holding the latest hit until we know if it is last.
    logic [CNT_W-1:0] r_issue_idx;
    logic             r_pipe_vld;
    logic [IDX_W-1:0] r_pipe_slot;
    logic             r_buf_vld;
    logic [IDX_W-1:0] r_buf_slot;
    logic [7:0]       r_buf_handler;
    logic [HIT_W-1:0] r_hits;
    logic             r_stop;

    logic             accept;
    logic [6:0]       neg_src;
    logic [1:0]       src_bank;
    logic [4:0]       src_bit;
    logic [31:0]      src_mask;
    logic             table_full;
    logic             reg_write;
    t_entry           wr_entry;
    logic             rd_en;
    t_entry           rd_entry;
    logic [31:0]      sel_pend;
    logic             hit;
    logic             scan_done;

    assign accept = i_start && !o_busy;
    assign o_busy = (r_state != ST_IDLE);

    // Source number to bank and bit. Zero and negative numbers fall in the
    // basic bank at bit minus source, wrapping modulo 32 below minus 31.
    always_comb begin
        neg_src = 7'(-i_source);
        if (i_source[6] || (i_source == 7'sd0)) begin
            src_bank = BANK_BASIC;
            src_bit  = neg_src[4:0];
        end else if (i_source[5]) begin
            src_bank = BANK_TWO;
            src_bit  = i_source[4:0];
        end else begin
            src_bank = BANK_ONE;
            src_bit  = i_source[4:0];
        end
        src_mask = 32'd1 << src_bit;
    end

    assign table_full = (r_count >= CNT_W'(TABLE_ENTRIES));
    assign reg_write  = accept && (i_func == FUNC_REGISTER) && !table_full;

    always_comb begin
        wr_entry.bank    = src_bank;
        wr_entry.bitpos  = src_bit;
        wr_entry.handler = i_handler_id;
    end

    // Reads stream out one slot per cycle until the table is exhausted or the
    // result limit has been reached.
    assign rd_en = (r_state == ST_SCAN) && !r_stop && (r_issue_idx < r_count);

    pidt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (reg_write),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (wr_entry),
        .i_re    (rd_en),
        .i_raddr (r_issue_idx[IDX_W-1:0]),
        .o_rdata (rd_entry)
    );

    // Pending test of the slot whose data just came back.
    always_comb begin
        case (rd_entry.bank)
            BANK_BASIC: sel_pend = r_pend_basic;
            BANK_ONE:   sel_pend = r_pend_one;
            default:    sel_pend = r_pend_two;
        endcase
        hit = r_pipe_vld && !r_stop && sel_pend[rd_entry.bitpos];
    end

    assign scan_done = r_stop || (!rd_en && !r_pipe_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_en_basic  <= '0;
            r_en_one    <= '0;
            r_en_two    <= '0;
            r_pipe_vld  <= 1'b0;
            r_buf_vld   <= 1'b0;
            r_stop      <= 1'b0;
            r_hits      <= '0;
            r_issue_idx <= '0;
            o_strobe    <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        unique case (i_func)
                            FUNC_REGISTER: begin
                                o_strobe <= 1'b1;
                                o_kind   <= KIND_REG;
                                o_last   <= 1'b1;
                                if (table_full) begin
                                    o_accepted    <= 1'b0;
                                    o_entry_index <= 3'd0;
                                    o_handler_out <= 8'd0;
                                end else begin
                                    o_accepted    <= 1'b1;
                                    o_entry_index <= slot_to_index(r_count[IDX_W-1:0]);
                                    o_handler_out <= i_handler_id;
                                    r_count       <= r_count + CNT_W'(1);
                                end
                            end
                            FUNC_ENABLE, FUNC_DISABLE: begin
                                unique case (src_bank)
                                    BANK_BASIC: r_en_basic <= (i_func == FUNC_ENABLE)
                                        ? (r_en_basic | src_mask) : (r_en_basic & ~src_mask);
                                    BANK_ONE:   r_en_one <= (i_func == FUNC_ENABLE)
                                        ? (r_en_one | src_mask) : (r_en_one & ~src_mask);
                                    default:    r_en_two <= (i_func == FUNC_ENABLE)
                                        ? (r_en_two | src_mask) : (r_en_two & ~src_mask);
                                endcase
                            end
                            default: begin
                                r_pend_basic <= i_raw_basic & r_en_basic;
                                r_pend_one   <= i_raw_bank_one & r_en_one;
                                r_pend_two   <= i_raw_bank_two & r_en_two;
                                r_issue_idx  <= '0;
                                r_pipe_vld   <= 1'b0;
                                r_buf_vld    <= 1'b0;
                                r_hits       <= '0;
                                r_stop       <= 1'b0;
                                r_state      <= ST_SCAN;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    r_pipe_vld  <= rd_en;
                    r_pipe_slot <= r_issue_idx[IDX_W-1:0];
                    if (rd_en) begin
                        r_issue_idx <= r_issue_idx + CNT_W'(1);
                    end
                    // A new hit releases the buffered one, which is then known
                    // not to be the final beat.
                    if (hit) begin
                        if (r_buf_vld) begin
                            o_strobe      <= 1'b1;
                            o_kind        <= KIND_DISPATCH;
                            o_accepted    <= 1'b1;
                            o_entry_index <= slot_to_index(r_buf_slot);
                            o_handler_out <= r_buf_handler;
                            o_last        <= 1'b0;
                        end
                        r_buf_vld     <= 1'b1;
                        r_buf_slot    <= r_pipe_slot;
                        r_buf_handler <= rd_entry.handler;
                        r_hits        <= r_hits + HIT_W'(1);
                        if (r_hits == HIT_W'(RESULT_LIMIT - 1)) begin
                            r_stop <= 1'b1;
                        end
                    end
                    if (scan_done) begin
                        r_state <= ST_FLUSH;
                    end
                end
                ST_FLUSH: begin
                    if (r_buf_vld) begin
                        o_strobe      <= 1'b1;
                        o_kind        <= KIND_DISPATCH;
                        o_accepted    <= 1'b1;
                        o_entry_index <= slot_to_index(r_buf_slot);
                        o_handler_out <= r_buf_handler;
                        o_last        <= 1'b1;
                    end
                    r_buf_vld  <= 1'b0;
                    r_pipe_vld <= 1'b0;
                    r_state    <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/pidt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pidt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                           i_wdata,
    input  wire logic                                       i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/pidt_checker.sv
// Port-level checks for the priority interrupt dispatch table, bound to the top.
// Depends on pidt_pkg and priority_interrupt_dispatch_table_top.
`timescale 1ns / 1ps
`default_nettype none

module pidt_checker
    import pidt_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_start,
    input wire logic              o_busy,
    input wire logic [1:0]        i_func,
    input wire logic              o_strobe,
    input wire logic              o_kind,
    input wire logic              o_accepted,
    input wire logic [2:0]        o_entry_index,
    input wire logic [7:0]        o_handler_out,
    input wire logic              o_last
);

    // A registration is answered by exactly one final beat in the next cycle.
    a_reg_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_func == FUNC_REGISTER))
        |=> (o_strobe && (o_kind == KIND_REG) && o_last))
        else $error("registration not answered in the next cycle");

    // Enable and disable commands never produce a beat.
    a_mask_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && ((i_func == FUNC_ENABLE) || (i_func == FUNC_DISABLE)))
        |=> !o_strobe)
        else $error("mask update produced a result beat");

    // Dispatch beats come only out of a busy scan and are always accepted.
    a_dispatch_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_kind == KIND_DISPATCH))
        |-> ($past(o_busy) && o_accepted))
        else $error("dispatch beat outside a scan");

    // A refused registration reports a zero slot and handler.
    a_full_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_accepted)
        |-> ((o_kind == KIND_REG) && (o_entry_index == 3'd0) && (o_handler_out == 8'd0)))
        else $error("refused registration carries nonzero fields");

endmodule

bind priority_interrupt_dispatch_table_top pidt_checker u_pidt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_start       (i_start),
    .o_busy        (o_busy),
    .i_func        (i_func),
    .o_strobe      (o_strobe),
    .o_kind        (o_kind),
    .o_accepted    (o_accepted),
    .o_entry_index (o_entry_index),
    .o_handler_out (o_handler_out),
    .o_last        (o_last)
);

`default_nettype wire
